[rtl/core/vae_pkg.sv]
// Shared constants and types for the voice activity endpointer.
// No dependencies; compiled first.
`default_nettype none

package vae_pkg;

   // payload and register widths
   localparam int SAMPLE_W    = 16;
   localparam int PEAK_W      = 16;
   localparam int SPAN_W      = 24;
   localparam int STATUS_W    = 2;
   localparam int RATE_W      = 17;
   localparam int CFG_W       = 16;
   localparam int CAP_W       = 24;
   localparam int MS_W        = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // chunk duration scaling
   localparam int MS_PER_S   = 1000;
   localparam int MS_SCALE_W = $clog2(MS_PER_S);

   // parameter defaults
   localparam int DEF_POSITION_BITS = 24;
   localparam int DEF_MAX_CHUNK     = 4096;

   // register values after reset
   localparam logic [RATE_W-1:0] RST_SAMPLE_RATE = RATE_W'(16000);
   localparam logic [CFG_W-1:0]  RST_WARMUP      = CFG_W'(1600);
   localparam logic [CFG_W-1:0]  RST_THRESHOLD   = CFG_W'(3000);
   localparam logic [CFG_W-1:0]  RST_PREROLL     = CFG_W'(4800);
   localparam logic [CFG_W-1:0]  RST_TAILPAD     = CFG_W'(4800);
   localparam logic [CFG_W-1:0]  RST_AUTO_STOP   = CFG_W'(1500);
   localparam logic [CFG_W-1:0]  RST_NO_VOICE    = CFG_W'(5000);
   localparam logic [CAP_W-1:0]  RST_CAPACITY    = CAP_W'(480000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_RATE = 3'd0,
      CSR_WARMUP      = 3'd1,
      CSR_THRESHOLD   = 3'd2,
      CSR_PREROLL     = 3'd3,
      CSR_TAILPAD     = 3'd4,
      CSR_AUTO_STOP   = 3'd5,
      CSR_NO_VOICE    = 3'd6,
      CSR_CAPACITY    = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_RUNNING      = 2'd0,
      STAT_DONE_SILENCE = 2'd1,
      STAT_DONE_NOVOICE = 2'd2,
      STAT_DONE_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_DIVIDE = 2'd1,
      SEQ_UPDATE = 2'd2,
      SEQ_REPORT = 2'd3
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/core/vae_req_if.sv]
// Sample channel: valid/ready handshake carrying one audio sample.
// Depends on vae_pkg.
`default_nettype none

interface vae_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vae_pkg::SAMPLE_W-1:0] sample;
   logic                                chunk_end;

   modport source (output valid, output sample, output chunk_end, input ready);
   modport sink   (input valid, input sample, input chunk_end, output ready);
endinterface

`default_nettype wire

[rtl/core/vae_rsp_if.sv]
// Result channel: valid/ready handshake carrying one chunk report.
// Depends on vae_pkg.
`default_nettype none

interface vae_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vae_pkg::STATUS_W-1:0]  status;
   logic [vae_pkg::PEAK_W-1:0]    chunk_peak;
   logic                          voice_heard;
   logic [vae_pkg::SPAN_W-1:0]    span_start;
   logic [vae_pkg::SPAN_W-1:0]    span_end;

   modport source (output valid, output status, output chunk_peak, output voice_heard,
                   output span_start, output span_end, input ready);
   modport sink   (input valid, input status, input chunk_peak, input voice_heard,
                   input span_start, input span_end, output ready);
endinterface

`default_nettype wire

[rtl/core/voice_activity_endpointer.sv]
// Voice activity endpointer: chunk peak tracking, voice span and stop status.
// Depends on vae_pkg, vae_req_if and vae_rsp_if.
//
//   channel   direction  transaction
//   req_chan  in         one sample + chunk_end flag
//   rsp_chan  out        status, peak, voice flag, span (one per closed chunk)
//   csr_*     in         register write, index 0..7, no read-back
//
// A sample that does not close a chunk leaves the block idle. A closing sample
// holds ready low through divide, update and report: the chunk duration in ms
// comes from a restoring divider that retires one quotient bit per cycle.
// The report stage waits while the previous result is still held on rsp_chan.
// Synchronous reset loads the register defaults; no clearing pass.
`default_nettype none

module voice_activity_endpointer #(
   parameter int POSITION_BITS = vae_pkg::DEF_POSITION_BITS,
   parameter int MAX_CHUNK     = vae_pkg::DEF_MAX_CHUNK
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [vae_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vae_pkg::CSR_DATA_W-1:0]     csr_wdata,
   vae_req_if.sink                                 req_chan,
   vae_rsp_if.source                               rsp_chan
);

   localparam int PB     = POSITION_BITS;
   localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
   localparam int DIV_W  = CNT_W + vae_pkg::MS_SCALE_W;
   localparam int DCNT_W = $clog2(DIV_W);
   localparam int WIDE_W = ((PB > vae_pkg::SPAN_W) ? PB : vae_pkg::SPAN_W) + 1;
   localparam int RW     = vae_pkg::RATE_W;
   localparam int CW     = vae_pkg::CFG_W;

   // configuration
   logic [RW-1:0]                rate_ff, rate_in;
   logic [CW-1:0]                warmup_ff, warmup_in;
   logic [CW-1:0]                thresh_ff, thresh_in;
   logic [CW-1:0]                preroll_ff, preroll_in;
   logic [CW-1:0]                tailpad_ff, tailpad_in;
   logic [CW-1:0]                auto_stop_ff, auto_stop_in;
   logic [CW-1:0]                no_voice_ff, no_voice_in;
   logic [vae_pkg::CAP_W-1:0]    capacity_ff, capacity_in;

   // tracking state
   logic [CW-1:0]                warmup_left_ff, warmup_left_in;
   logic [PB-1:0]                position_ff, position_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [vae_pkg::PEAK_W-1:0]   peak_ff, peak_in;
   logic                         heard_ff, heard_in;
   logic [PB-1:0]                vstart_ff, vstart_in;
   logic [PB-1:0]                vend_ff, vend_in;
   logic [vae_pkg::MS_W-1:0]     silence_ff, silence_in;
   logic [vae_pkg::MS_W-1:0]     waiting_ff, waiting_in;

   // divider
   logic [DIV_W-1:0]             div_quot_ff, div_quot_in;
   logic [RW-1:0]                div_rem_ff, div_rem_in;
   logic [DCNT_W-1:0]            div_cnt_ff, div_cnt_in;

   vae_pkg::seq_state_type       state_ff, state_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   vae_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [vae_pkg::PEAK_W-1:0]   rsp_peak_ff, rsp_peak_in;
   logic                         rsp_heard_ff, rsp_heard_in;
   logic [vae_pkg::SPAN_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [vae_pkg::SPAN_W-1:0]   rsp_end_ff, rsp_end_in;

   // combinational helpers
   logic                         req_fire;
   logic [vae_pkg::PEAK_W-1:0]   mag;
   logic [CNT_W-1:0]             count_inc;
   logic [RW-1:0]                rate_eff;
   logic [RW:0]                  trial;
   logic                         trial_ge;
   logic [PB:0]                  pos_sum;
   logic [PB-1:0]                pos_sat;
   logic [vae_pkg::MS_W:0]       silence_sum, waiting_sum;
   logic [WIDE_W-1:0]            span_a, span_b, pos_wide;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == vae_pkg::SEQ_IDLE);

   assign mag       = req_chan.sample[vae_pkg::SAMPLE_W-1] ? (~req_chan.sample + 1'b1)
                                                          : req_chan.sample;
   assign count_inc = count_ff + 1'b1;
   assign rate_eff  = (rate_ff == '0) ? RW'(1) : rate_ff;

   assign trial    = {div_rem_ff, div_quot_ff[DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, rate_eff});

   assign pos_sum     = (PB+1)'(position_ff) + (PB+1)'(count_ff);
   assign pos_sat     = pos_sum[PB] ? '1 : pos_sum[PB-1:0];
   // quotient is already in div_quot_ff once the sequencer reaches update
   assign silence_sum = {1'b0, silence_ff} + (vae_pkg::MS_W+1)'(div_quot_ff);
   assign waiting_sum = {1'b0, waiting_ff} + (vae_pkg::MS_W+1)'(div_quot_ff);

   assign pos_wide = WIDE_W'(position_ff);

   always_comb begin
      // padded span, clipped to the current position
      span_a = WIDE_W'(vstart_ff);
      span_b = WIDE_W'(vend_ff) + WIDE_W'(tailpad_ff);
      if (span_b > pos_wide) begin
         span_b = pos_wide;
      end
      if (span_a >= span_b) begin
         span_a = '0;
         span_b = pos_wide;
      end
   end

   always_comb begin
      rate_in      = rate_ff;
      warmup_in    = warmup_ff;
      thresh_in    = thresh_ff;
      preroll_in   = preroll_ff;
      tailpad_in   = tailpad_ff;
      auto_stop_in = auto_stop_ff;
      no_voice_in  = no_voice_ff;
      capacity_in  = capacity_ff;

      warmup_left_in = warmup_left_ff;
      position_in    = position_ff;
      count_in       = count_ff;
      peak_in        = peak_ff;
      heard_in       = heard_ff;
      vstart_in      = vstart_ff;
      vend_in        = vend_ff;
      silence_in     = silence_ff;
      waiting_in     = waiting_ff;

      div_quot_in = div_quot_ff;
      div_rem_in  = div_rem_ff;
      div_cnt_in  = div_cnt_ff;
      state_in    = state_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_heard_in  = rsp_heard_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;

      case (state_ff)
         vae_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               if (warmup_left_ff != '0) begin
                  warmup_left_in = warmup_left_ff - 1'b1;
               end else begin
                  peak_in  = (mag > peak_ff) ? mag : peak_ff;
                  count_in = count_inc;
                  // oversized chunk closes itself
                  if (req_chan.chunk_end || count_inc == CNT_W'(MAX_CHUNK)) begin
                     div_quot_in = DIV_W'(count_inc) * DIV_W'(vae_pkg::MS_PER_S);
                     div_rem_in  = '0;
                     div_cnt_in  = '0;
                     state_in    = vae_pkg::SEQ_DIVIDE;
                  end
               end
            end
         end
         vae_pkg::SEQ_DIVIDE: begin
            div_rem_in  = trial_ge ? RW'(trial - {1'b0, rate_eff}) : trial[RW-1:0];
            div_quot_in = {div_quot_ff[DIV_W-2:0], trial_ge};
            div_cnt_in  = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = vae_pkg::SEQ_UPDATE;
            end
         end
         vae_pkg::SEQ_UPDATE: begin
            if (peak_ff >= thresh_ff) begin
               if (!heard_ff) begin
                  heard_in  = 1'b1;
                  vstart_in = (position_ff > PB'(preroll_ff)) ? position_ff - PB'(preroll_ff)
                                                              : '0;
               end
               vend_in    = pos_sat;
               silence_in = '0;
            end else if (heard_ff) begin
               silence_in = silence_sum[vae_pkg::MS_W] ? '1 : silence_sum[vae_pkg::MS_W-1:0];
            end else begin
               waiting_in = waiting_sum[vae_pkg::MS_W] ? '1 : waiting_sum[vae_pkg::MS_W-1:0];
            end
            position_in = pos_sat;
            state_in    = vae_pkg::SEQ_REPORT;
         end
         vae_pkg::SEQ_REPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               if (heard_ff && silence_ff >= vae_pkg::MS_W'(auto_stop_ff)) begin
                  rsp_status_in = vae_pkg::STAT_DONE_SILENCE;
               end else if (!heard_ff && waiting_ff >= vae_pkg::MS_W'(no_voice_ff)) begin
                  rsp_status_in = vae_pkg::STAT_DONE_NOVOICE;
               end else if (pos_wide >= WIDE_W'(capacity_ff)) begin
                  rsp_status_in = vae_pkg::STAT_DONE_FULL;
               end else begin
                  rsp_status_in = vae_pkg::STAT_RUNNING;
               end
               rsp_peak_in  = peak_ff;
               rsp_heard_in = heard_ff;
               rsp_start_in = span_a[vae_pkg::SPAN_W-1:0];
               rsp_end_in   = span_b[vae_pkg::SPAN_W-1:0];
               count_in     = '0;
               peak_in      = '0;
               state_in     = vae_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = vae_pkg::SEQ_IDLE;
         end
      endcase

      if (csr_we) begin
         case (vae_pkg::csr_index_type'(csr_index))
            vae_pkg::CSR_SAMPLE_RATE: rate_in = csr_wdata[RW-1:0];
            vae_pkg::CSR_WARMUP: begin
               warmup_in      = csr_wdata[CW-1:0];
               warmup_left_in = csr_wdata[CW-1:0];
            end
            vae_pkg::CSR_THRESHOLD:   thresh_in    = csr_wdata[CW-1:0];
            vae_pkg::CSR_PREROLL:     preroll_in   = csr_wdata[CW-1:0];
            vae_pkg::CSR_TAILPAD:     tailpad_in   = csr_wdata[CW-1:0];
            vae_pkg::CSR_AUTO_STOP:   auto_stop_in = csr_wdata[CW-1:0];
            vae_pkg::CSR_NO_VOICE:    no_voice_in  = csr_wdata[CW-1:0];
            vae_pkg::CSR_CAPACITY:    capacity_in  = csr_wdata[vae_pkg::CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= vae_pkg::RST_SAMPLE_RATE;
         warmup_ff      <= vae_pkg::RST_WARMUP;
         thresh_ff      <= vae_pkg::RST_THRESHOLD;
         preroll_ff     <= vae_pkg::RST_PREROLL;
         tailpad_ff     <= vae_pkg::RST_TAILPAD;
         auto_stop_ff   <= vae_pkg::RST_AUTO_STOP;
         no_voice_ff    <= vae_pkg::RST_NO_VOICE;
         capacity_ff    <= vae_pkg::RST_CAPACITY;
         warmup_left_ff <= vae_pkg::RST_WARMUP;
         position_ff    <= '0;
         count_ff       <= '0;
         peak_ff        <= '0;
         heard_ff       <= 1'b0;
         vstart_ff      <= '0;
         vend_ff        <= '0;
         silence_ff     <= '0;
         waiting_ff     <= '0;
         state_ff       <= vae_pkg::SEQ_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rate_ff        <= rate_in;
         warmup_ff      <= warmup_in;
         thresh_ff      <= thresh_in;
         preroll_ff     <= preroll_in;
         tailpad_ff     <= tailpad_in;
         auto_stop_ff   <= auto_stop_in;
         no_voice_ff    <= no_voice_in;
         capacity_ff    <= capacity_in;
         warmup_left_ff <= warmup_left_in;
         position_ff    <= position_in;
         count_ff       <= count_in;
         peak_ff        <= peak_in;
         heard_ff       <= heard_in;
         vstart_ff      <= vstart_in;
         vend_ff        <= vend_in;
         silence_ff     <= silence_in;
         waiting_ff     <= waiting_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      div_quot_ff   <= div_quot_in;
      div_rem_ff    <= div_rem_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_heard_ff  <= rsp_heard_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.chunk_peak  = rsp_peak_ff;
   assign rsp_chan.voice_heard = rsp_heard_ff;
   assign rsp_chan.span_start  = rsp_start_ff;
   assign rsp_chan.span_end    = rsp_end_ff;

endmodule

`default_nettype wire

[tb/sv/voice_activity_endpointer_tb.sv]
// Testbench for voice_activity_endpointer. It drives sample transactions and register writes,
// predicts every chunk report and checks each one against the result channel.
// Depends on vae_pkg, vae_req_if, vae_rsp_if and the voice_activity_endpointer RTL.

module voice_activity_endpointer_tb;
   import vae_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 40;     // margin for a closing sample to finish
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int IDLE_PERCENT  = 37;
   localparam int MAX_LOG       = 50;
   localparam int unsigned PEAK_MAX  = 32768;
   localparam int unsigned CHUNK_MAX = DEF_MAX_CHUNK;
   localparam longint unsigned POS_LIMIT = (64'd1 << DEF_POSITION_BITS) - 1;

   typedef struct packed {
      status_type        status;
      logic [PEAK_W-1:0] peak;
      logic              heard;
      logic [SPAN_W-1:0] span_start;
      logic [SPAN_W-1:0] span_end;
   } chunk_report_type;

   // Tracks peak, voice span and silence timers; holds the reports still owed by the block.
   class span_scoreboard;
      int unsigned rate_hz, warmup_len, threshold, preroll, tailpad;
      int unsigned stop_ms, novoice_ms, capacity;
      int unsigned warm_left, position, run_len, peak_now;
      int unsigned voice_start, voice_end, silence_ms, waiting_ms;
      bit heard;
      chunk_report_type expected_reports[$];
      int unsigned mismatches, reports_checked, kept, dropped;
      int unsigned status_seen[4];

      function new();
         rate_hz    = RST_SAMPLE_RATE;
         warmup_len = RST_WARMUP;
         threshold  = RST_THRESHOLD;
         preroll    = RST_PREROLL;
         tailpad    = RST_TAILPAD;
         stop_ms    = RST_AUTO_STOP;
         novoice_ms = RST_NO_VOICE;
         capacity   = RST_CAPACITY;
         warm_left  = warmup_len;
      endfunction

      function int unsigned clip_position(longint unsigned v);
         return (v > POS_LIMIT) ? 32'(POS_LIMIT) : 32'(v);
      endfunction

      function int unsigned add_ms(int unsigned a, int unsigned b);
         longint unsigned total;
         total = longint'(a) + b;
         return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(total);
      endfunction

      function void write_reg(csr_index_type idx, int unsigned value);
         case (idx)
            CSR_SAMPLE_RATE: rate_hz = value & 32'h1FFFF;
            CSR_WARMUP: begin
               warmup_len = value & 32'hFFFF;
               warm_left  = warmup_len;
            end
            CSR_THRESHOLD: threshold  = value & 32'hFFFF;
            CSR_PREROLL:   preroll    = value & 32'hFFFF;
            CSR_TAILPAD:   tailpad    = value & 32'hFFFF;
            CSR_AUTO_STOP: stop_ms    = value & 32'hFFFF;
            CSR_NO_VOICE:  novoice_ms = value & 32'hFFFF;
            CSR_CAPACITY:  capacity   = value & 32'hFF_FFFF;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw, bit closes);
         int unsigned mag, rate, ms_len;
         longint unsigned tail;
         chunk_report_type r;
         if (warm_left != 0) begin
            warm_left--;
            dropped++;
            return;
         end
         kept++;
         mag = raw[SAMPLE_W-1] ? 32'h10000 - raw : raw;
         if (mag > peak_now) peak_now = mag;
         run_len++;
         if (run_len >= CHUNK_MAX) closes = 1;
         if (!closes) return;

         rate   = (rate_hz == 0) ? 1 : rate_hz;
         ms_len = 32'((longint'(run_len) * MS_PER_S) / rate);
         if (peak_now >= threshold) begin
            if (!heard) begin
               heard       = 1;
               voice_start = (position > preroll) ? position - preroll : 0;
            end
            voice_end  = clip_position(longint'(position) + run_len);
            silence_ms = 0;
         end else if (heard)
            silence_ms = add_ms(silence_ms, ms_len);
         else
            waiting_ms = add_ms(waiting_ms, ms_len);
         position = clip_position(longint'(position) + run_len);

         if (heard && silence_ms >= stop_ms)
            r.status = STAT_DONE_SILENCE;
         else if (!heard && waiting_ms >= novoice_ms)
            r.status = STAT_DONE_NOVOICE;
         else if (position >= capacity)
            r.status = STAT_DONE_FULL;
         else
            r.status = STAT_RUNNING;

         // padded end is clipped to what has been kept; an empty span falls back to 0..position
         tail = longint'(voice_end) + tailpad;
         if (tail > position) tail = position;
         r.span_start = SPAN_W'(voice_start);
         if (voice_start >= tail) begin
            r.span_start = '0;
            tail         = position;
         end
         r.span_end = SPAN_W'(tail);
         r.peak     = PEAK_W'(peak_now);
         r.heard    = heard;
         run_len    = 0;
         peak_now   = 0;
         status_seen[r.status]++;
         expected_reports.push_back(r);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_LOG) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_report(chunk_report_type got);
         chunk_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("report with none pending, peak %0d", got.peak));
            return;
         end
         want = expected_reports.pop_front();
         reports_checked++;
         if (got.status !== want.status)
            report_mismatch($sformatf("report %0d status %0d, want %0d",
                                      reports_checked, got.status, want.status));
         if (got.peak !== want.peak)
            report_mismatch($sformatf("report %0d peak %0d, want %0d",
                                      reports_checked, got.peak, want.peak));
         if (got.heard !== want.heard)
            report_mismatch($sformatf("report %0d voice_heard %0b, want %0b",
                                      reports_checked, got.heard, want.heard));
         if (got.span_start !== want.span_start)
            report_mismatch($sformatf("report %0d span_start %0d, want %0d",
                                      reports_checked, got.span_start, want.span_start));
         if (got.span_end !== want.span_end)
            report_mismatch($sformatf("report %0d span_end %0d, want %0d",
                                      reports_checked, got.span_end, want.span_end));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   vae_req_if req_chan();
   vae_rsp_if rsp_chan();

   voice_activity_endpointer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   span_scoreboard tracker;
   bit          calm;
   bit          hold_request;
   int unsigned samples_sent;
   int unsigned holds_done;
   int          stall_cycles = 0;

   initial clock = 0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] loud_sample();
      int unsigned mag;
      if (tracker.threshold > PEAK_MAX || $urandom_range(3) == 0) return SAMPLE_W'($urandom);
      mag = $urandom_range(PEAK_MAX, tracker.threshold);
      if (mag == PEAK_MAX || $urandom_range(1) == 1) return SAMPLE_W'(-int'(mag));
      return SAMPLE_W'(mag);
   endfunction

   function automatic logic [SAMPLE_W-1:0] quiet_sample();
      int unsigned mag;
      if (tracker.threshold == 0) return SAMPLE_W'($urandom);
      mag = $urandom_range((tracker.threshold > PEAK_MAX) ? PEAK_MAX - 1 : tracker.threshold - 1,
                           0);
      return ($urandom_range(1) == 1) ? SAMPLE_W'(-int'(mag)) : SAMPLE_W'(mag);
   endfunction

   function automatic int unsigned chunk_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 90) return $urandom_range(16, 1);
      if (pick < 98) return $urandom_range(120, 17);
      return $urandom_range(600, 121);
   endfunction

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   task automatic configure(input int unsigned rate, warm, thr, pre, tail, stop, quiet, cap);
      write_csr(CSR_SAMPLE_RATE, rate);
      write_csr(CSR_WARMUP, warm);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_PREROLL, pre);
      write_csr(CSR_TAILPAD, tail);
      write_csr(CSR_AUTO_STOP, stop);
      write_csr(CSR_NO_VOICE, quiet);
      write_csr(CSR_CAPACITY, cap);
      csr_we <= 1'b0;
   endtask

   task automatic push_sample(input logic [SAMPLE_W-1:0] value, input bit closes);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sample    <= value;
      req_chan.chunk_end <= closes;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_sample(value, closes);
      samples_sent++;
   endtask

   task automatic send_chunk(input int unsigned len, input bit loud);
      int unsigned hot;
      hot = $urandom_range(len - 1, 0);
      for (int unsigned i = 0; i < len; i++)
         push_sample((loud && i == hot) ? loud_sample() : quiet_sample(), i == len - 1);
   endtask

   // Speech-like traffic: talk and pause stretches, with stray samples mixed in.
   task automatic random_traffic(input int unsigned items, input bit short_chunks);
      int unsigned stop_at;
      bit talking;
      stop_at = samples_sent + items;
      talking = 0;
      while (samples_sent < stop_at) begin
         if ($urandom_range(99) < 20) talking = !talking;
         if ($urandom_range(99) < 80)
            send_chunk(short_chunks ? $urandom_range(3, 1) : chunk_len(),
                       $urandom_range(99) < (talking ? 80 : 10));
         else
            push_sample(SAMPLE_W'($urandom), $urandom_range(1));
      end
   endtask

   // Wait until every report is in, then give a discarded or partial chunk time to finish.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tracker.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      tracker            = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_SAMPLE_RATE;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.sample    = '0;
      req_chan.chunk_end = 1'b0;
      calm               = 0;
      hold_request       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no voice possible; tiny limits so running, full and no-voice all show up
      configure(1000, 3, 65535, 20, 0, 0, 15, 12);
      push_sample(16'h1234, 0);
      push_sample(16'hFFFF, 1);     // chunk end on a warm-up sample: whole chunk dropped
      push_sample(16'h0000, 0);
      push_sample(16'h8000, 1);     // most negative sample, peak 32768
      push_sample(16'h7FFF, 0);
      push_sample(16'h8001, 0);
      push_sample(16'h0000, 1);
      push_sample(16'h0000, 1);
      push_sample(16'h0001, 0);
      push_sample(16'hFFFF, 1);
      push_sample(16'h5555, 0);
      push_sample(16'hAAAA, 0);
      push_sample(16'h5555, 0);
      push_sample(16'hAAAA, 1);
      push_sample(16'h00FF, 0);
      push_sample(16'hFF00, 0);
      push_sample(16'h0F0F, 1);     // buffer full while still waiting
      push_sample(16'hF0F0, 0);
      push_sample(16'h3333, 1);     // no-voice wins over full
      random_traffic(100, 0);
      settle();

      configure(96000, 2, 65535, 20, 9, 0, 65535, 1);
      random_traffic(80, 0);
      settle();

      // zero rate counts as one sample per second
      configure(0, 1, 65535, 20, 50000, 0, 65535, 16777215);
      random_traffic(60, 0);
      settle();

      // first voice lands well past the pre-roll
      configure(16000, 1, 3000, 17, 100, 15, 0, 16777215);
      random_traffic(200, 0);
      settle();

      configure(131071, 0, 32768, 65535, 65535, 65535, 65535, 16777215);
      random_traffic(120, 0);
      settle();

      configure(1000, 2, 0, 0, 0, 0, 0, 1);
      random_traffic(80, 0);
      settle();

      // long warm-up: everything dropped, chunk ends included
      configure(1000, 65535, 3000, 0, 0, 100, 0, 480000);
      repeat (6) push_sample(SAMPLE_W'($urandom), $urandom_range(1));
      settle();

      // receiver holds off while short chunks keep coming, so the input backs up
      configure(1000, 0, 2000, 4800, 300, 60, 5000, 8000);
      hold_request = 1;
      random_traffic(120, 1);
      hold_request = 1;
      random_traffic(80, 1);
      settle();

      calm = 1;
      configure(44100, 4, 12000, 0, 1000, 200, 100, 16777215);
      random_traffic(200, 0);
      settle();
      calm = 0;

      repeat (2) begin
         configure($urandom_range(96000, 1000), $urandom_range(8), $urandom_range(PEAK_MAX),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(400),
                   $urandom_range(65535), $urandom_range(16777215, 1));
         random_traffic(150, 0);
         settle();
      end

      $display("%0d samples sent (%0d dropped in warm-up), %0d chunk reports checked",
               samples_sent, tracker.dropped, tracker.reports_checked);
      $display("statuses: running %0d, silence %0d, no voice %0d, full %0d; %0d hold-offs",
               tracker.status_seen[STAT_RUNNING], tracker.status_seen[STAT_DONE_SILENCE],
               tracker.status_seen[STAT_DONE_NOVOICE], tracker.status_seen[STAT_DONE_FULL],
               holds_done);
      if (tracker.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // result side: check each transaction, then pick the next ready level
   initial begin
      chunk_report_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status     = status_type'(rsp_chan.status);
            got.peak       = rsp_chan.chunk_peak;
            got.heard      = rsp_chan.voice_heard;
            got.span_start = rsp_chan.span_start;
            got.span_end   = rsp_chan.span_end;
            tracker.check_report(got);
         end
         if (hold_request) begin
            hold_request = 0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else
            rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else if (stall_cycles == STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d reports outstanding",
                  STALL_LIMIT, tracker.expected_reports.size());
         $display("== FAIL ==");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

endmodule

[filelist.f]
rtl/core/vae_pkg.sv
rtl/core/vae_req_if.sv
rtl/core/vae_rsp_if.sv
rtl/core/voice_activity_endpointer.sv
tb/sv/voice_activity_endpointer_tb.sv
